// File: rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// Needs nothing else; each macro expands to one concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/ffds_pkg.sv
// Types and constants for the flat face diffuse shader.
// Used by the top level and its checker; depends on nothing.
package ffds_pkg;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_COLOR_RED     = 3'd0,
      CSR_COLOR_GREEN   = 3'd1,
      CSR_COLOR_BLUE    = 3'd2,
      CSR_AMBIENT_COEFF = 3'd3,
      CSR_DIFFUSE_COEFF = 3'd4,
      CSR_AMBIENT_INT   = 3'd5,
      CSR_POINT_INT     = 3'd6,
      CSR_LIGHT_POS     = 3'd7
   } csr_index_type;

   localparam int unsigned FIELD_W  = 16;
   localparam int unsigned SHADE_W  = 19;
   localparam int unsigned REQ_W    = 96;
   localparam int unsigned RSP_W    = 64;
   localparam int unsigned CSR_W    = 48;

   // Iteration counts of the square root and divider pipelines.
   localparam int unsigned SQRT_STEPS = 32;
   localparam int unsigned DIV_STEPS  = 17;
   // Total register stages from input to output register.
   localparam int unsigned NUM_STAGES = 4 + SQRT_STEPS + 1 + DIV_STEPS + 5;

   localparam logic signed [24:0] SHADE_MAX = 25'sd262143;
   localparam logic signed [24:0] SHADE_MIN = -25'sd262144;

endpackage

// File: rtl/flat_face_diffuse_shader.sv
// Flat diffuse shader: one face (unit normal and first vertex) enters per clock on the req
// stream and its shaded color is shown on the rsp stream through 59 register stages; most of
// them are the 32-step square root pipeline that normalizes the light vector and the 17-step
// divider pipeline that forms the cosine. A stall on rsp freezes the whole pipeline, so
// req_tready follows rsp_tready whenever a result waits. The user must write configuration
// through the csr port only while no face is in flight; the block does not enforce this.
// Depends on ffds_pkg.
module flat_face_diffuse_shader
   import ffds_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // normal_x, normal_y, normal_z, vertex_x, vertex_y, vertex_z, 16 bits each
   input  logic [REQ_W-1:0]    req_tdata,
   input  logic                req_tvalid,
   output logic                req_tready,
   // shade_red, shade_green, shade_blue, 19 bits each, then 7 zero bits
   output logic [RSP_W-1:0]    rsp_tdata,
   // zero_light_vector
   output logic                rsp_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [CSR_W-1:0]    csr_data
);

   // Configuration registers.
   logic [15:0] color_ff [0:2];
   logic [15:0] amb_coeff_ff, dif_coeff_ff, amb_int_ff, pt_int_ff;
   logic [47:0] light_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff[0]  <= 16'hFFFF;
         color_ff[1]  <= 16'hFFFF;
         color_ff[2]  <= 16'hFFFF;
         amb_coeff_ff <= '0;
         dif_coeff_ff <= '0;
         amb_int_ff   <= '0;
         pt_int_ff    <= '0;
         light_ff     <= '0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_COLOR_RED:     color_ff[0]  <= csr_data[15:0];
            CSR_COLOR_GREEN:   color_ff[1]  <= csr_data[15:0];
            CSR_COLOR_BLUE:    color_ff[2]  <= csr_data[15:0];
            CSR_AMBIENT_COEFF: amb_coeff_ff <= csr_data[15:0];
            CSR_DIFFUSE_COEFF: dif_coeff_ff <= csr_data[15:0];
            CSR_AMBIENT_INT:   amb_int_ff   <= csr_data[15:0];
            CSR_POINT_INT:     pt_int_ff    <= csr_data[15:0];
            CSR_LIGHT_POS:     light_ff     <= csr_data;
            default:           light_ff     <= light_ff;
         endcase
      end
   end

   // Products of configuration values; they settle while the block is idle.
   logic [31:0] amb_prod_ff, pt_prod_ff;
   always_ff @(posedge clock) begin
      amb_prod_ff <= amb_int_ff * amb_coeff_ff;
      pt_prod_ff  <= pt_int_ff * dif_coeff_ff;
   end

   // Global advance: the pipeline moves unless a finished result is held.
   logic adv;
   logic [NUM_STAGES-1:0] vld_ff;
   assign adv        = rsp_tready || !vld_ff[NUM_STAGES-1];
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NUM_STAGES-2:0], req_tvalid};
      end
   end

   // Stage 0: light vector per axis.
   logic signed [16:0] lvec_ff [0:2];
   logic signed [15:0] nrm_ff  [0:2];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            lvec_ff[i] <= 17'(signed'(light_ff[16*i +: 16]))
                        - 17'(signed'(req_tdata[16*(i+3) +: 16]));
            nrm_ff[i]  <= signed'(req_tdata[16*i +: 16]);
         end
      end
   end

   // Stage 1: squares and normal products.
   logic        [31:0] lsq_ff [0:2];
   logic signed [32:0] np_ff  [0:2];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            lsq_ff[i] <= 32'(unsigned'(34'(lvec_ff[i] * lvec_ff[i])));
            np_ff[i]  <= 33'(nrm_ff[i] * lvec_ff[i]);
         end
      end
   end

   // Stage 2: squared length and dot product.
   logic        [33:0] ssum_ff;
   logic signed [34:0] dot_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         ssum_ff <= 34'(lsq_ff[0]) + 34'(lsq_ff[1]) + 34'(lsq_ff[2]);
         dot_ff  <= 35'(np_ff[0]) + 35'(np_ff[1]) + 35'(np_ff[2]);
      end
   end

   // Square root pipeline, one result bit per stage; entry is stage 3.
   logic [62:0] sqn_ff  [0:SQRT_STEPS];
   logic [62:0] sqr_ff  [0:SQRT_STEPS];
   logic [33:0] smag_ff [0:SQRT_STEPS];
   logic        sneg_ff [0:SQRT_STEPS];
   logic        szero_ff[0:SQRT_STEPS];

   always_ff @(posedge clock) begin
      if (adv) begin
         sqn_ff[0]   <= {1'b0, ssum_ff[33:0], 28'd0};
         sqr_ff[0]   <= '0;
         smag_ff[0]  <= dot_ff[34] ? 34'(-dot_ff) : 34'(dot_ff);
         sneg_ff[0]  <= dot_ff[34];
         szero_ff[0] <= (ssum_ff == '0);
      end
   end

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      localparam logic [62:0] BIT = 63'd1 << (62 - 2*k);
      logic [62:0] trial;
      logic        take;
      assign trial = sqr_ff[k] + BIT;
      assign take  = (sqn_ff[k] >= trial);
      always_ff @(posedge clock) begin
         if (adv) begin
            sqn_ff[k+1]   <= take ? sqn_ff[k] - trial : sqn_ff[k];
            sqr_ff[k+1]   <= take ? (sqr_ff[k] >> 1) + BIT : (sqr_ff[k] >> 1);
            smag_ff[k+1]  <= smag_ff[k];
            sneg_ff[k+1]  <= sneg_ff[k];
            szero_ff[k+1] <= szero_ff[k];
         end
      end
   end

   // Divider pipeline: q = floor((2*num + r) / (2*r)), one quotient bit per stage.
   logic [48:0] drem_ff [0:DIV_STEPS];
   logic [32:0] ddiv_ff [0:DIV_STEPS];
   logic [16:0] dq_ff   [0:DIV_STEPS];
   logic        dneg_ff [0:DIV_STEPS];
   logic        dzero_ff[0:DIV_STEPS];

   always_ff @(posedge clock) begin
      if (adv) begin
         drem_ff[0]  <= {smag_ff[SQRT_STEPS], 15'd0}
                      + 49'(sqr_ff[SQRT_STEPS][31:0]);
         ddiv_ff[0]  <= {sqr_ff[SQRT_STEPS][31:0], 1'b0};
         dq_ff[0]    <= '0;
         dneg_ff[0]  <= sneg_ff[SQRT_STEPS];
         dzero_ff[0] <= szero_ff[SQRT_STEPS];
      end
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      localparam int unsigned SH = DIV_STEPS - 1 - j;
      logic [48:0] dsh;
      logic        take;
      assign dsh  = 49'(ddiv_ff[j]) << SH;
      assign take = (drem_ff[j] >= dsh);
      always_ff @(posedge clock) begin
         if (adv) begin
            drem_ff[j+1]  <= take ? drem_ff[j] - dsh : drem_ff[j];
            ddiv_ff[j+1]  <= ddiv_ff[j];
            dq_ff[j+1]    <= dq_ff[j] | (take ? (17'd1 << SH) : 17'd0);
            dneg_ff[j+1]  <= dneg_ff[j];
            dzero_ff[j+1] <= dzero_ff[j];
         end
      end
   end

   // Signed cosine; a zero light vector drops the diffuse term.
   logic signed [17:0] cos_ff;
   logic               zero_c_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         if (dzero_ff[DIV_STEPS]) begin
            cos_ff <= '0;
         end else if (dneg_ff[DIV_STEPS]) begin
            cos_ff <= -signed'({1'b0, dq_ff[DIV_STEPS]});
         end else begin
            cos_ff <= signed'({1'b0, dq_ff[DIV_STEPS]});
         end
         zero_c_ff <= dzero_ff[DIV_STEPS];
      end
   end

   // Diffuse product.
   logic signed [50:0] dif_ff;
   logic               zero_d_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         dif_ff    <= 51'(signed'({1'b0, pt_prod_ff}) * cos_ff);
         zero_d_ff <= zero_c_ff;
      end
   end

   // Intensity: ambient plus diffuse, rounded shift by 22.
   logic signed [51:0] isum;
   logic        [51:0] imag;
   logic        [29:0] irnd;
   logic signed [30:0] inten_ff;
   logic               zero_i_ff;
   assign isum = 52'(signed'({1'b0, amb_prod_ff, 14'd0})) + 52'(dif_ff);
   assign imag = isum[51] ? 52'(-isum) : 52'(isum);
   assign irnd = 30'((imag + (52'd1 << 21)) >> 22);
   always_ff @(posedge clock) begin
      if (adv) begin
         inten_ff  <= isum[51] ? -signed'({1'b0, irnd}) : signed'({1'b0, irnd});
         zero_i_ff <= zero_d_ff;
      end
   end

   // Color products.
   logic signed [47:0] prod_ff [0:2];
   logic               zero_p_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            prod_ff[i] <= 48'(inten_ff * signed'({1'b0, color_ff[i]}));
         end
         zero_p_ff <= zero_i_ff;
      end
   end

   // Rounding, saturation and the output register.
   logic [SHADE_W-1:0] shade_ff [0:2];
   logic               zero_o_ff;
   for (genvar c = 0; c < 3; c++) begin : g_out
      logic        [47:0] pmag;
      logic        [23:0] prnd;
      logic signed [24:0] pval;
      assign pmag = prod_ff[c][47] ? 48'(-prod_ff[c]) : 48'(prod_ff[c]);
      assign prnd = 24'((pmag + (48'd1 << 23)) >> 24);
      assign pval = prod_ff[c][47] ? -signed'({1'b0, prnd}) : signed'({1'b0, prnd});
      always_ff @(posedge clock) begin
         if (adv) begin
            if (pval > SHADE_MAX) begin
               shade_ff[c] <= SHADE_MAX[SHADE_W-1:0];
            end else if (pval < SHADE_MIN) begin
               shade_ff[c] <= SHADE_MIN[SHADE_W-1:0];
            end else begin
               shade_ff[c] <= pval[SHADE_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         zero_o_ff <= zero_p_ff;
      end
   end

   assign rsp_tdata  = {7'd0, shade_ff[2], shade_ff[1], shade_ff[0]};
   assign rsp_tuser  = zero_o_ff;
   assign rsp_tvalid = vld_ff[NUM_STAGES-1];

endmodule

// File: rtl/ffds_chk.sv
// Port-level checker for the flat face diffuse shader and its bind.
// Depends on ffds_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ffds_chk
   import ffds_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_tready,
   input logic [RSP_W-1:0]    rsp_tdata,
   input logic                rsp_tuser,
   input logic                rsp_tvalid,
   input logic                rsp_tready
);

   // A held result keeps its beat.
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "rsp beat changed while stalled")

   // A held result stops intake.
   `ASSERT_CLK(a_stall_in, clock, reset, rsp_tvalid && !rsp_tready |-> !req_tready, "input taken during output stall")

   // Reset empties the pipeline.
   `ASSERT_CLK_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "result after reset")

   // Padding bits of the result beat stay zero.
   `ASSERT_CLK(a_pad_zero, clock, reset, rsp_tvalid |-> rsp_tdata[RSP_W-1:3*SHADE_W] == '0, "nonzero padding")

endmodule

bind flat_face_diffuse_shader ffds_chk u_ffds_chk (.*);

// File: tb/ffds_checker.sv
// Checker for the flat face diffuse shader: watches the face, result and register channels,
// predicts each shaded color and compares it field by field with what the block returns.
// Depends on ffds_pkg.
`timescale 1ns / 1ps
module ffds_checker
   import ffds_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [RSP_W-1:0] rsp_tdata,
   input  logic             rsp_tuser,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [CSR_W-1:0] csr_data,
   output int               fail_count,
   output int               pending_shades,
   output int               checked_shades,
   output int               zero_light_seen
);

   typedef struct packed {
      logic signed [SHADE_W-1:0] red;
      logic signed [SHADE_W-1:0] green;
      logic signed [SHADE_W-1:0] blue;
      logic                      zero_light;
   } shade_type;

   // Shadow copy of the configuration registers.
   logic [15:0] color_reg [3];
   logic [15:0] amb_coeff, dif_coeff, amb_int, pt_int;
   logic [47:0] light_pos;

   shade_type shade_queue [$];

   // Running totals, all kept by the result process.
   int fails     = 0;
   int pending   = 0;
   int checked   = 0;
   int zero_seen = 0;

   assign fail_count      = fails;
   assign pending_shades  = pending;
   assign checked_shades  = checked;
   assign zero_light_seen = zero_seen;

   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n   = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // Shift right with rounding to nearest, ties away from zero.
   function automatic longint shift_round(input longint v, input int k);
      longint unsigned mag;
      mag = (v < 0) ? longint'(-v) : v;
      mag = (mag + (64'd1 << (k - 1))) >> k;
      return (v < 0) ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic logic signed [SHADE_W-1:0] clip_shade(input longint v);
      if (v > 262143) return 19'sd262143;
      if (v < -262144) return -19'sd262144;
      return v[SHADE_W-1:0];
   endfunction

   function automatic shade_type shade_face(input logic [REQ_W-1:0] face);
      longint          lvec, dot, cosv, amb, dif, inten;
      longint unsigned sq, root, mag, num, quo;
      shade_type       s;
      dot = 0;
      sq  = 0;
      cosv = 0;
      for (int i = 0; i < 3; i++) begin
         lvec = longint'($signed(light_pos[16*i +: 16])) -
                longint'($signed(face[16*(i+3) +: 16]));
         sq  += longint'(lvec * lvec);
         dot += longint'($signed(face[16*i +: 16])) * lvec;
      end
      if (sq != 0) begin
         root = int_sqrt(sq << 28);
         mag  = (dot < 0) ? longint'(-dot) : dot;
         num  = mag << 14;
         quo  = (2 * num + root) / (2 * root);
         cosv = (dot < 0) ? -longint'(quo) : longint'(quo);
      end
      amb   = longint'(amb_int) * longint'(amb_coeff) * 16384;
      dif   = longint'(pt_int) * longint'(dif_coeff) * cosv;
      inten = shift_round(amb + dif, 22);
      s.red        = clip_shade(shift_round(inten * longint'(color_reg[0]), 24));
      s.green      = clip_shade(shift_round(inten * longint'(color_reg[1]), 24));
      s.blue       = clip_shade(shift_round(inten * longint'(color_reg[2]), 24));
      s.zero_light = (sq == 0);
      return s;
   endfunction

   task automatic report_mismatch(input string field, input longint got, input longint want);
      $display("%0t mismatch on %s: got %0d, expected %0d", $time, field, got, want);
      fails++;
   endtask

   // Register writes update the shadow copy.
   always @(posedge clock) begin
      if (reset) begin
         color_reg[0] <= 16'hFFFF;
         color_reg[1] <= 16'hFFFF;
         color_reg[2] <= 16'hFFFF;
         amb_coeff    <= '0;
         dif_coeff    <= '0;
         amb_int      <= '0;
         pt_int       <= '0;
         light_pos    <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_COLOR_RED:     color_reg[0] <= csr_data[15:0];
            CSR_COLOR_GREEN:   color_reg[1] <= csr_data[15:0];
            CSR_COLOR_BLUE:    color_reg[2] <= csr_data[15:0];
            CSR_AMBIENT_COEFF: amb_coeff    <= csr_data[15:0];
            CSR_DIFFUSE_COEFF: dif_coeff    <= csr_data[15:0];
            CSR_AMBIENT_INT:   amb_int      <= csr_data[15:0];
            CSR_POINT_INT:     pt_int       <= csr_data[15:0];
            CSR_LIGHT_POS:     light_pos    <= csr_data;
            default: ;
         endcase
      end
   end

   // Each accepted face beat queues its expected shade; each result beat is checked.
   always @(posedge clock) begin
      shade_type want, got;
      if (!reset) begin
         if (req_tvalid && req_tready) shade_queue.push_back(shade_face(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.red        = rsp_tdata[18:0];
            got.green      = rsp_tdata[37:19];
            got.blue       = rsp_tdata[56:38];
            got.zero_light = rsp_tuser;
            if (shade_queue.size() == 0) begin
               $display("%0t result beat with no face outstanding", $time);
               fails++;
            end else begin
               want = shade_queue.pop_front();
               checked++;
               if (want.zero_light) zero_seen++;
               if (got.red != want.red) report_mismatch("shade_red", got.red, want.red);
               if (got.green != want.green)
                  report_mismatch("shade_green", got.green, want.green);
               if (got.blue != want.blue) report_mismatch("shade_blue", got.blue, want.blue);
               if (got.zero_light != want.zero_light)
                  report_mismatch("zero_light_vector", got.zero_light, want.zero_light);
            end
         end
         pending = shade_queue.size();
      end
   end

endmodule

// File: tb/tb_flat_face_diffuse_shader.sv
// Top of the flat face diffuse shader testbench: clock, reset, face and register stimulus,
// receiver stalls and the verdict. Depends on ffds_pkg, ffds_checker and the shader itself.
`timescale 1ns / 1ps
module tb_flat_face_diffuse_shader;
   import ffds_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_LEN    = 300;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tuser;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [2:0]       csr_index = '0;
   logic [CSR_W-1:0] csr_data = '0;

   int fail_count, pending_shades, checked_shades, zero_light_seen;
   int cycles = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_count = 0;
   logic hold_req = 1'b0;
   logic hold_done = 1'b0;
   logic [47:0] light_now = '0;

   flat_face_diffuse_shader u_dut (.*);

   ffds_checker u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Receiver: random stalls, or one long hold-off once it is requested.
   always @(posedge clock) begin
      if (hold_req && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_count <= hold_count + 1;
         if (hold_count == HOLD_LEN - 1) hold_done <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [47:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_LIGHT_POS) light_now = value;
   endtask

   // Waits until every face has its result, then lets the pipeline drain.
   task automatic drain_pipe();
      @(negedge clock);
      while (pending_shades != 0) @(negedge clock);
      repeat (NUM_STAGES + 10) @(posedge clock);
   endtask

   task automatic send_face(input logic [REQ_W-1:0] face);
      req_tvalid <= 1'b1;
      req_tdata  <= face;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   function automatic logic [15:0] pick_field();
      case ($urandom_range(5))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // Half the faces have random normal components in [-16384, 16384], the rest full-range
   // normals; vertices are random, and some faces sit exactly on the light.
   function automatic logic [REQ_W-1:0] random_face();
      logic [15:0] n [3];
      logic [47:0] v;
      int sel;
      sel = $urandom_range(9);
      for (int i = 0; i < 3; i++)
         n[i] = (sel < 5) ? 16'($signed($urandom_range(0, 32768)) - 16384) : pick_field();
      v = {pick_field(), pick_field(), pick_field()};
      if (sel == 9) v = light_now;
      return {v, n[2], n[1], n[0]};
   endfunction

   task automatic load_config(input int kind);
      logic [15:0] r [7];
      logic [47:0] lp;
      for (int i = 0; i < 7; i++) begin
         case (kind)
            0:       r[i] = 16'hFFFF;
            1:       r[i] = 16'h0000;
            default: r[i] = 16'($urandom);
         endcase
      end
      lp = (kind == 0) ? 48'h7FFF_8000_7FFF : (kind == 1) ? 48'h0 : 48'({$urandom, $urandom});
      write_reg(CSR_COLOR_RED, 48'(r[0]));
      write_reg(CSR_COLOR_GREEN, 48'(r[1]));
      write_reg(CSR_COLOR_BLUE, 48'(r[2]));
      write_reg(CSR_AMBIENT_COEFF, 48'(r[3]));
      write_reg(CSR_DIFFUSE_COEFF, 48'(r[4]));
      write_reg(CSR_AMBIENT_INT, 48'(r[5]));
      write_reg(CSR_POINT_INT, 48'(r[6]));
      write_reg(CSR_LIGHT_POS, lp);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: fixed light, axis and extreme normals, extreme vertices, face on the light.
      write_reg(CSR_AMBIENT_COEFF, 48'h8000);
      write_reg(CSR_DIFFUSE_COEFF, 48'hC000);
      write_reg(CSR_AMBIENT_INT, 48'h0800);
      write_reg(CSR_POINT_INT, 48'h1000);
      write_reg(CSR_LIGHT_POS, 48'h0400_0200_0100);
      send_face({48'h0, 48'h0000_0000_4000});
      send_face({48'h0, 48'h0000_4000_0000});
      send_face({48'h0, 48'h4000_0000_0000});
      send_face({48'h0, 48'hC000_C000_C000});
      send_face({48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF});
      send_face({48'h8000_8000_8000, 48'h8000_8000_8000});
      send_face({48'h7FFF_8000_7FFF, 48'h8000_7FFF_8000});
      send_face({48'h0400_0200_0100, 48'h0000_0000_4000});
      send_face({48'h0400_0200_0101, 48'h0000_0000_4000});
      send_face({48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF});
      req_tvalid <= 1'b0;
      drain_pipe();
      load_config(0);
      send_face({48'h7FFF_8000_7FFF, 48'h0000_0000_0000});
      send_face({48'h8000_7FFF_8000, 48'h7FFF_7FFF_7FFF});
      send_face({48'h8000_7FFF_8000, 48'h8000_8000_8000});
      send_face({48'h0, 48'h4000_4000_4000});
      req_tvalid <= 1'b0;
      drain_pipe();
      load_config(1);
      send_face({48'h1234_5678_9ABC, 48'h4000_0000_0000});
      send_face({48'h0, 48'h0});
      req_tvalid <= 1'b0;
      drain_pipe();

      // Random phases: no idling with one long receiver hold-off, sender idle, receiver stalling, both.
      for (int ph = 0; ph < 4; ph++) begin
         load_config((ph == 3) ? 0 : 2);
         send_idle_pct = (ph == 1) ? 56 : (ph == 3) ? 22 : 0;
         stall_pct     = (ph == 2) ? 56 : (ph == 3) ? 22 : 0;
         if (ph == 0) hold_req <= 1'b1;
         for (int n = 0; n < 210; n++) begin
            send_face(random_face());
            if (n == 150) begin
               req_tvalid <= 1'b0;
               drain_pipe();
            end
         end
         req_tvalid <= 1'b0;
         drain_pipe();
      end
      stall_pct = 0;

      $display("Shaded %0d faces, %0d of them lit from zero distance, over several light",
               checked_shades, zero_light_seen);
      $display("and color settings with sender gaps and receiver stalls.");
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
